// ----- sv/fmpf_pkg.sv -----
// Shared types and constants for the first-match packet filter.
// No dependencies; imported by every module of the block.
`default_nettype none
package fmpf_pkg;

  localparam int MAX_RULES = 16;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int MI_W      = 4;

  localparam logic [1:0] KIND_CHECK = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] WILD_CODE  = 2'd2;

  typedef enum logic [1:0] {
    OP_CHECK,
    OP_ADD,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        rule_allow;
    logic [1:0]  protocol;
    logic [1:0]  direction;
    logic [31:0] ip_addr;
    logic [15:0] port_num;
  } cmd_t;

  typedef struct packed {
    logic            verdict;
    logic            matched;
    logic [MI_W-1:0] match_index;
    logic            add_rejected;
  } result_t;

  typedef struct packed {
    logic        allow;
    logic [1:0]  protocol;
    logic [1:0]  direction;
    logic [31:0] ip_addr;
    logic [15:0] port_num;
  } rule_t;

  typedef struct packed {
    op_t   op;
    rule_t rule;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t ent;
  } qpush_t;

endpackage
`default_nettype wire

// ----- sv/first_match_packet_filter_core.sv -----
// Top level of the first-match packet filter: front end, queue, rule engine.
// Depends on fmpf_pkg, fmpf_front, fmpf_queue, fmpf_back.
//
//   channel  | handshake        | beat
//   command  | start / busy     | cmd    (kind, rule_allow, protocol, direction, ip_addr, port_num)
//   result   | done (strobe)    | result (verdict, matched, match_index, add_rejected)
//
// One command per cycle sustained; done rises after the queue slot and then the done register.
// All rules are compared in parallel; the engine retires one queued op per cycle.
// Reset empties the rule table (count only) and the queue; no clearing pass.
// The engine pops every cycle, so the queue never fills and busy stays low.
`default_nettype none
module first_match_packet_filter_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire fmpf_pkg::cmd_t    cmd,
  output logic                   busy,
  output logic                   done,
  output fmpf_pkg::result_t      result
);
  import fmpf_pkg::*;

  qpush_t qp;
  qent_t  head;
  logic   q_full;
  logic   q_valid;
  logic   pop;

  fmpf_front u_front (
    .start  (start),
    .cmd    (cmd),
    .q_full (q_full),
    .busy   (busy),
    .qp     (qp)
  );

  fmpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .qp        (qp),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  fmpf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule
`default_nettype wire

// ----- sv/fmpf_front.sv -----
// Front end: accepts command beats and classifies them into queue entries.
// Depends on fmpf_pkg.
`default_nettype none
module fmpf_front (
  input  wire logic          start,
  input  wire fmpf_pkg::cmd_t cmd,
  input  wire logic          q_full,
  output logic               busy,
  output fmpf_pkg::qpush_t   qp
);
  import fmpf_pkg::*;

  always_comb begin
    busy              = q_full;
    qp.push           = start && !q_full;
    qp.ent.rule.allow     = cmd.rule_allow;
    qp.ent.rule.protocol  = cmd.protocol;
    qp.ent.rule.direction = cmd.direction;
    qp.ent.rule.ip_addr   = cmd.ip_addr;
    qp.ent.rule.port_num  = cmd.port_num;
    unique case (cmd.kind)
      KIND_CHECK: qp.ent.op = OP_CHECK;
      KIND_ADD:   qp.ent.op = OP_ADD;
      KIND_CLEAR: qp.ent.op = OP_CLEAR;
      default:    qp.ent.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/fmpf_queue.sv -----
// Two-entry queue decoupling the front end from the rule engine.
// Depends on fmpf_pkg.
`default_nettype none
module fmpf_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fmpf_pkg::qpush_t qp,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output fmpf_pkg::qent_t       head
);
  import fmpf_pkg::*;

  qent_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_pop;

  assign do_pop    = pop && (fill != 2'd0);
  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (qp.push) begin
      slots[wr_ptr] <= qp.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (qp.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (qp.push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (!qp.push && do_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !qp.push || do_pop) else $error("queue overflow");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3) else $error("queue fill out of range");

endmodule
`default_nettype wire

// ----- sv/fmpf_back.sv -----
// Rule engine: holds the rule table, executes one queued op per cycle and
// registers the result beat. Depends on fmpf_pkg.
`default_nettype none
module fmpf_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire fmpf_pkg::qent_t head,
  output logic                 pop,
  output logic                 done,
  output fmpf_pkg::result_t    result
);
  import fmpf_pkg::*;

  rule_t            rules [MAX_RULES];
  logic [CNT_W-1:0] rule_count;
  logic [CNT_W-1:0] rule_count_next;
  logic             table_full;
  logic [MAX_RULES-1:0] hit;
  logic             any_hit;
  logic [IDX_W-1:0] hit_idx;
  logic             do_write;
  result_t          result_next;

  assign pop        = q_valid;
  assign table_full = (rule_count == CNT_W'(MAX_RULES));

  always_comb begin
    for (int i = 0; i < MAX_RULES; i++) begin
      hit[i] = (CNT_W'(i) < rule_count)
        && (rules[i].protocol == head.rule.protocol || rules[i].protocol == WILD_CODE)
        && (rules[i].direction == head.rule.direction || rules[i].direction == WILD_CODE)
        && (rules[i].ip_addr == head.rule.ip_addr || rules[i].ip_addr == 32'd0)
        && (rules[i].port_num == head.rule.port_num || rules[i].port_num == 16'd0);
    end
  end

  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = MAX_RULES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    result_next     = '{verdict: 1'b1, matched: 1'b0, match_index: '0, add_rejected: 1'b0};
    rule_count_next = rule_count;
    do_write        = 1'b0;
    unique case (head.op)
      OP_CHECK: begin
        if (any_hit) begin
          result_next.verdict     = rules[hit_idx].allow;
          result_next.matched     = 1'b1;
          result_next.match_index = MI_W'(hit_idx);
        end
      end
      OP_ADD: begin
        if (table_full) begin
          result_next.add_rejected = 1'b1;
        end else begin
          do_write        = q_valid;
          rule_count_next = rule_count + CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        rule_count_next = '0;
      end
      OP_NOP: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      rules[rule_count[IDX_W-1:0]] <= head.rule;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= q_valid;
      if (q_valid) begin
        rule_count <= rule_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid) begin
      result <= result_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rule_count <= CNT_W'(MAX_RULES)) else $error("rule count beyond table");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    q_valid && head.op == OP_ADD && !table_full |=> rule_count == $past(rule_count) + CNT_W'(1))
    else $error("accepted add did not grow table");

  a_nomatch_idx: assert property (@(posedge clk) disable iff (rst)
    done && !result.matched |-> result.match_index == '0 && result.verdict)
    else $error("default verdict malformed");

  a_reject_excl: assert property (@(posedge clk) disable iff (rst)
    done && result.add_rejected |-> !result.matched && $past(table_full))
    else $error("reject without full table");

endmodule
`default_nettype wire
